>>> hw/rtl/swa_pkg.sv
// Shared types, constants and state encoding for the per-slot wait average block.
`default_nettype none

package swa_pkg;

  localparam int NUM_SLOTS_DEF  = 8;
  localparam int MAX_WINDOW_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int SLOT_IN_W = 3;
  localparam int WAIT_W    = 20;
  localparam int COUNT_W   = 16;
  localparam int AVG_W     = 28;
  localparam int HELD_W    = 5;
  localparam int WINDOW_W  = 5;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(16);

  typedef struct packed {
    logic [SLOT_IN_W-1:0]      instance_slot;
    logic [WAIT_W-1:0]         wait_time;
    logic signed [COUNT_W-1:0] queued_count;
  } in_item_t;

  typedef struct packed {
    logic              bad_count;
    logic [AVG_W-1:0]  average_load;
    logic [HELD_W-1:0] samples_held;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_UPDATE,
    ST_AVERAGE,
    ST_FINISH
  } swa_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/swa_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module swa_div
  import swa_pkg::*;
#(
  parameter int DVD_W = 33,
  parameter int DVS_W = COUNT_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  always_comb begin
    rem_sh = {rem, quotient[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= CNT_W'(DVD_W);
    end else if (busy) begin
      // A clear borrow bit means the shifted remainder covers the divisor.
      if (!diff[DVS_W]) begin
        rem      <= diff[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], 1'b0};
      end
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/swa_ring.sv
// Sample ring storage for all slots, one write and one registered read port.
`default_nettype none

module swa_ring
  import swa_pkg::*;
#(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 28
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/per_slot_windowed_wait_average.sv
// Per-slot sliding-window average of per-message wait load.
// Each item with a non-negative count makes two passes through the shared divider, which
// yields one quotient bit per cycle; a negative count skips the divider entirely.
// One transaction at a time: a new item is accepted only after the last result is loaded.
// Reset and every window_size write clear head, fill and sum of all slots at once;
// ring entries are only read after being written, so the ring itself is never swept.
`default_nettype none

module per_slot_windowed_wait_average
  import swa_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [WINDOW_W-1:0] cfg_wr_data
);

  localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
  localparam int SAMPLE_W = WAIT_W + FRAC_BITS;
  localparam int SUM_W    = SAMPLE_W + FILL_W;
  localparam int DEPTH    = NUM_SLOTS * MAX_WINDOW;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W    = (FILL_W > WINDOW_W) ? FILL_W : WINDOW_W;

  swa_state_t state, state_next;

  logic [WINDOW_W-1:0] window_size;
  logic [POS_W-1:0]    head [NUM_SLOTS];
  logic [FILL_W-1:0]   fill [NUM_SLOTS];
  logic [SUM_W-1:0]    sum  [NUM_SLOTS];

  logic [SLOT_W-1:0]   slot;
  logic                bad;
  logic [SAMPLE_W-1:0] sample;
  logic [FILL_W-1:0]   held;

  logic                accept;
  logic                load;
  logic                do_update;
  logic                div_start;
  logic [SUM_W-1:0]    div_dividend;
  logic [COUNT_W-1:0]  div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [SUM_W-1:0]    div_quotient;

  logic [SLOT_IN_W-1:0] slot_red;
  logic [SLOT_W-1:0]    slot_in;
  logic [CMP_W-1:0]     win_eff;
  logic [CMP_W-1:0]     win_ext;
  logic                 evict;
  logic [POS_W-1:0]     head_cur;
  logic [FILL_W-1:0]    fill_cur;
  logic [POS_W-1:0]     head_new;
  logic [FILL_W-1:0]    fill_mid;
  logic [FILL_W-1:0]    fill_new;
  logic [FILL_W:0]      pos_sum;
  logic [POS_W-1:0]     pos;
  logic [SUM_W-1:0]     sum_new;
  logic [ADDR_W-1:0]    waddr;
  logic [ADDR_W-1:0]    raddr;
  logic [SAMPLE_W-1:0]  rdata;

  assign accept = in_valid && in_ready;

  // Slot indexes beyond the slot count wrap around.
  always_comb begin
    slot_red = in_data.instance_slot;
    for (int i = 0; i < (1 << SLOT_IN_W); i++) begin
      if (int'(slot_red) >= NUM_SLOTS) begin
        slot_red = slot_red - SLOT_IN_W'(NUM_SLOTS);
      end
    end
    slot_in = SLOT_W'(slot_red);
  end

  always_comb begin
    win_ext = CMP_W'(window_size);
    if (window_size == '0) begin
      win_eff = CMP_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      win_eff = CMP_W'(MAX_WINDOW);
    end else begin
      win_eff = win_ext;
    end
  end

  // Ring bookkeeping for the slot that is being updated.
  always_comb begin
    head_cur = head[slot];
    fill_cur = fill[slot];
    evict    = CMP_W'(fill_cur) >= win_eff;
    if (evict) begin
      head_new = (head_cur == POS_W'(MAX_WINDOW - 1)) ? '0 : head_cur + POS_W'(1);
      fill_mid = fill_cur - FILL_W'(1);
    end else begin
      head_new = head_cur;
      fill_mid = fill_cur;
    end
    fill_new = fill_mid + FILL_W'(1);
    pos_sum  = (FILL_W + 1)'(head_new) + (FILL_W + 1)'(fill_mid);
    if (int'(pos_sum) >= MAX_WINDOW) begin
      pos = POS_W'(pos_sum - (FILL_W + 1)'(MAX_WINDOW));
    end else begin
      pos = POS_W'(pos_sum);
    end
    sum_new = sum[slot] - (evict ? SUM_W'(rdata) : '0) + SUM_W'(sample);
    waddr   = ADDR_W'(slot) * ADDR_W'(MAX_WINDOW) + ADDR_W'(pos);
    raddr   = ADDR_W'(slot) * ADDR_W'(MAX_WINDOW) + ADDR_W'(head_cur);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = in_data.queued_count[COUNT_W-1] ? ST_FINISH : ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE:  state_next = ST_AVERAGE;
      ST_AVERAGE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    do_update    = 1'b0;
    load         = 1'b0;
    div_dividend = SUM_W'({in_data.wait_time, {FRAC_BITS{1'b0}}});
    div_divisor  = COUNT_W'(in_data.queued_count) + COUNT_W'(1);
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        div_start = accept && !in_data.queued_count[COUNT_W-1];
      end
      ST_UPDATE: begin
        do_update    = 1'b1;
        div_start    = 1'b1;
        div_dividend = sum_new;
        div_divisor  = COUNT_W'(fill_new);
      end
      ST_FINISH: load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
        sum[i]  <= '0;
      end
    end else if (do_update) begin
      head[slot] <= head_new;
      fill[slot] <= fill_new;
      sum[slot]  <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= slot_in;
      bad  <= in_data.queued_count[COUNT_W-1];
    end
    if (state == ST_SAMPLE && div_done) begin
      sample <= SAMPLE_W'(div_quotient);
    end
    if (do_update) begin
      held <= fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.bad_count <= bad;
      if (bad) begin
        out_data.average_load <= '0;
        out_data.samples_held <= '0;
      end else begin
        out_data.average_load <= AVG_W'(div_quotient);
        out_data.samples_held <= HELD_W'(held);
      end
    end
  end

  swa_div #(
    .DVD_W (SUM_W),
    .DVS_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  swa_ring #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_W)
  ) u_ring (
    .clk   (clk),
    .we    (do_update),
    .waddr (waddr),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while still busy");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_SAMPLE || state == ST_AVERAGE))
    else $error("divider result arrived outside a division state");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    do_update |-> (CMP_W'(fill_new) <= win_eff))
    else $error("slot fill exceeds the window");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("new transaction taken while one is in progress");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (fill[0] == '0 && sum[0] == '0))
    else $error("window write did not clear slot state");

endmodule

`default_nettype wire

>>> dv/wait_average_checker.sv
// Checker for the per-slot wait average block: predicts every result and compares it.
`timescale 1ns / 1ps

module wait_average_checker
  import swa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [WINDOW_W-1:0] cfg_wr_data,
  output int                  errors,
  output int                  pending
);

  localparam int SLOTS     = NUM_SLOTS_DEF;
  localparam int WIN_MAX   = MAX_WINDOW_DEF;
  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int HEAD_W    = $clog2(WIN_MAX);
  localparam int EXP_DEPTH = 8;
  localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

  logic [AVG_W-1:0]    ring [SLOTS][WIN_MAX];
  logic [HEAD_W-1:0]   oldest [SLOTS];
  logic [HELD_W-1:0]   held [SLOTS];
  logic [31:0]         slot_sum [SLOTS];
  logic [WINDOW_W-1:0] window_reg;

  // Expected results in arrival order, kept as a small circular buffer.
  out_item_t            exp_buf [EXP_DEPTH];
  logic [EXP_PTR_W-1:0] exp_wr;
  logic [EXP_PTR_W-1:0] exp_rd;
  int                   exp_count;
  out_item_t            want;
  out_item_t            pred;
  int                   result_idx;

  task automatic clear_slots();
    for (int s = 0; s < SLOTS; s++) begin
      oldest[s]   = '0;
      held[s]     = '0;
      slot_sum[s] = '0;
      for (int k = 0; k < WIN_MAX; k++) ring[s][k] = '0;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns: result %0d: %s", $time, result_idx, msg);
    errors++;
  endtask

  // Flags a bad count, else pushes a sample to its slot window; returns the average.
  function automatic out_item_t advance_slot_average(in_item_t it);
    int unsigned slot;
    int unsigned limit;
    int unsigned pos;
    logic [63:0] divisor;
    logic [63:0] sample;
    out_item_t   r;
    r = '0;
    if (it.queued_count[COUNT_W-1]) begin
      r.bad_count = 1'b1;
      return r;
    end
    slot    = it.instance_slot % SLOTS;
    limit   = (window_reg == 0) ? 1 : (window_reg > WIN_MAX) ? WIN_MAX : window_reg;
    divisor = {48'd0, it.queued_count} + 64'd1;
    sample  = ({44'd0, it.wait_time} << FRAC) / divisor;
    if (held[slot] >= limit) begin
      slot_sum[slot] = slot_sum[slot] - ring[slot][oldest[slot]];
      oldest[slot]   = oldest[slot] + 1'b1;
      held[slot]     = held[slot] - 1'b1;
    end
    pos = (oldest[slot] + held[slot]) % WIN_MAX;
    ring[slot][pos] = sample[AVG_W-1:0];
    held[slot]      = held[slot] + 1'b1;
    slot_sum[slot]  = slot_sum[slot] + sample[31:0];
    r.samples_held  = held[slot];
    r.average_load  = AVG_W'(slot_sum[slot] / held[slot]);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_slots();
      window_reg = WINDOW_RESET;
      exp_wr     = '0;
      exp_rd     = '0;
      exp_count  = 0;
      result_idx = 0;
      pending <= 0;
    end else begin
      // Results are retired before new transactions are predicted in the same cycle.
      if (out_valid && out_ready) begin
        if (exp_count == 0) begin
          report_mismatch("result arrived with no transaction waiting");
        end else begin
          want      = exp_buf[exp_rd];
          exp_rd    = exp_rd + 1'b1;
          exp_count = exp_count - 1;
          if (out_data.bad_count !== want.bad_count)
            report_mismatch($sformatf("bad_count got %0d expected %0d",
                                      out_data.bad_count, want.bad_count));
          if (out_data.average_load !== want.average_load)
            report_mismatch($sformatf("average_load got %0d expected %0d",
                                      out_data.average_load, want.average_load));
          if (out_data.samples_held !== want.samples_held)
            report_mismatch($sformatf("samples_held got %0d expected %0d",
                                      out_data.samples_held, want.samples_held));
        end
        result_idx++;
      end
      if (cfg_wr_en) begin
        window_reg = cfg_wr_data;
        clear_slots();
      end
      if (in_valid && in_ready) begin
        pred = advance_slot_average(in_data);
        if (exp_count == EXP_DEPTH) begin
          report_mismatch("more transactions in flight than the block can hold");
        end else begin
          exp_buf[exp_wr] = pred;
          exp_wr          = exp_wr + 1'b1;
          exp_count       = exp_count + 1;
        end
      end
      pending <= exp_count;
    end
  end

  final begin
    if (exp_count != 0) begin
      $display("%0d results never arrived", exp_count);
    end
  end

endmodule

>>> dv/per_slot_windowed_wait_average_tb.sv
// Testbench top for the per-slot wait average block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module per_slot_windowed_wait_average_tb;
  import swa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 150;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_wr_en;
  logic [WINDOW_W-1:0] cfg_wr_data;

  int errors;
  int pending;
  int stall_cycles = 0;
  int sent = 0;
  int rejected = 0;
  int windows_used = 1;
  int gap_pct = 30;
  int stall_pct = 30;
  bit calm = 1'b0;

  // Window settings per random phase: saturation at both ends and a few in between.
  logic [WINDOW_W-1:0] phase_window [10] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd17,
                                             5'd5, 5'd3, 5'd16, 5'd8, 5'd12};

  always #4 clk = ~clk;

  per_slot_windowed_wait_average DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  wait_average_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .pending    (pending)
  );

  // Ends the run when neither channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("per_slot_windowed_wait_average_tb: FAIL");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (it.queued_count[COUNT_W-1]) rejected++;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  task automatic send_fields(int slot, logic [WAIT_W-1:0] wt, logic signed [COUNT_W-1:0] cnt);
    in_item_t it;
    it.instance_slot = SLOT_IN_W'(slot);
    it.wait_time     = wt;
    it.queued_count  = cnt;
    send_item(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_window(logic [WINDOW_W-1:0] w);
    drain();
    repeat (8) @(negedge clk);
    cfg_wr_data <= w;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    windows_used++;
  endtask

  function automatic in_item_t random_item(int slot_hi);
    in_item_t it;
    int       pick;
    it.instance_slot = SLOT_IN_W'($urandom_range(0, slot_hi));
    case ($urandom_range(0, 7))
      0:       it.wait_time = '0;
      1:       it.wait_time = WAIT_MAX;
      2:       it.wait_time = WAIT_W'($urandom_range(0, 255));
      default: it.wait_time = WAIT_W'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.queued_count = COUNT_W'($urandom) | 16'h8000;
    end else if (pick < 55) begin
      it.queued_count = COUNT_W'($urandom_range(0, 7));
    end else if (pick < 62) begin
      it.queued_count = 16'sh7fff;
    end else begin
      it.queued_count = COUNT_W'($urandom_range(0, 32767));
    end
    return it;
  endfunction

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset window of 16: field extremes and rejected counts.
    send_fields(0, '0, 16'sd0);
    send_fields(0, WAIT_MAX, 16'sd0);
    send_fields(7, WAIT_MAX, 16'sh7fff);
    send_fields(3, 20'd1, 16'sd2);
    send_fields(3, 20'd1000, -16'sd1);
    send_fields(5, WAIT_MAX, 16'sh8000);
    send_fields(1, 20'd12345, 16'sd6);
    send_fields(2, 20'haaaaa, 16'sh5555);
    send_fields(4, 20'h55555, 16'sh2aaa);
    send_fields(6, 20'd7, 16'sd0);
    send_fields(0, WAIT_MAX, 16'sd0);
    send_fields(0, WAIT_MAX, 16'sd0);
    send_fields(0, WAIT_MAX, 16'sd1);
    send_fields(7, '0, 16'sh7fff);
    send_fields(6, 20'd3, 16'sd1);

    // A window of two: the third push on a slot drops its oldest sample.
    write_window(5'd2);
    send_fields(2, 20'd100, 16'sd0);
    send_fields(2, 20'd200, 16'sd0);
    send_fields(2, 20'd400, 16'sd0);
    send_fields(2, 20'd50, -16'sd7);
    send_fields(2, 20'd800, 16'sd3);

    for (int p = 0; p < 10; p++) begin
      int slot_hi;
      write_window(phase_window[p]);
      slot_hi   = (p % 3 == 0) ? 7 : (p % 3 == 1) ? 1 : 3;
      gap_pct   = (p % 4 == 2) ? 0 : $urandom_range(5, 60);
      stall_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 60);
      calm      = (p == 9);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold the sender back once until the block has returned every result.
        if (p == 3 && i == 50) drain();
        send_item(random_item(slot_hi));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d transactions, %0d with negative counts, over %0d window settings",
             sent, rejected, windows_used);
    $display("including window values 0, 1 and 31 and window wraparound on busy slots.");
    if (errors == 0) begin
      $display("per_slot_windowed_wait_average_tb: PASS");
    end else begin
      $display("per_slot_windowed_wait_average_tb: FAIL");
    end
    $finish;
  end

endmodule
